>>> hdl/dsfd_pkg.sv
// Package for the dust sensor frame decoder.
// Frame constants, state and status codes, result struct. No dependencies.
package dsfd_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'hAA;
    localparam logic [7:0] TAIL_BYTE   = 8'hFF;

    localparam int RAW_W  = 16;
    localparam int CONC_W = 19;

    // Position within a frame, one-hot
    typedef enum logic [6:0] {
        S_HUNT   = 7'b000_0001,
        S_CNT_HI = 7'b000_0010,
        S_CNT_LO = 7'b000_0100,
        S_REF_A  = 7'b000_1000,
        S_REF_B  = 7'b001_0000,
        S_CHKSUM = 7'b010_0000,
        S_TAIL   = 7'b100_0000
    } t_frame_state;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TAIL_ERR = 2'd1,
        ST_CSUM_ERR = 2'd2
    } t_status;

    // Finished frame from the tracker to the result stage
    typedef struct packed {
        logic             done;
        logic [RAW_W-1:0] raw;
        t_status          status;
    } t_frame_res;

endpackage

>>> hdl/dsfd_frame_fsm.sv
// Frame tracker: hunts for the header, gathers the count, checks sum and tail.
// Depends on dsfd_pkg.
module dsfd_frame_fsm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    output dsfd_pkg::t_frame_res o_res
);
    import dsfd_pkg::*;

    t_frame_state r_state, n_state;
    logic [7:0]   r_sum, n_sum;
    logic [7:0]   r_hi, n_hi;
    logic [7:0]   r_lo, n_lo;
    logic         r_csum_bad, n_csum_bad;

    // Next state and the result of a tail byte
    always_comb begin
        n_state    = r_state;
        n_sum      = r_sum;
        n_hi       = r_hi;
        n_lo       = r_lo;
        n_csum_bad = r_csum_bad;
        o_res.done   = 1'b0;
        o_res.raw    = {r_hi, r_lo};
        o_res.status = ST_OK;
        unique case (r_state)
            S_CNT_HI: begin
                n_hi    = i_byte;
                n_sum   = r_sum + i_byte;
                n_state = S_CNT_LO;
            end
            S_CNT_LO: begin
                n_lo    = i_byte;
                n_sum   = r_sum + i_byte;
                n_state = S_REF_A;
            end
            S_REF_A: begin
                n_sum   = r_sum + i_byte;
                n_state = S_REF_B;
            end
            S_REF_B: begin
                n_sum   = r_sum + i_byte;
                n_state = S_CHKSUM;
            end
            S_CHKSUM: begin
                n_csum_bad = (i_byte != r_sum);
                n_state    = S_TAIL;
            end
            S_TAIL: begin
                // tail error outranks a checksum error
                o_res.done = i_step;
                if (i_byte != TAIL_BYTE) begin
                    o_res.status = ST_TAIL_ERR;
                end else if (r_csum_bad) begin
                    o_res.status = ST_CSUM_ERR;
                end
                n_state = S_HUNT;
            end
            default: begin
                if (i_byte == HEADER_BYTE) begin
                    n_state    = S_CNT_HI;
                    n_sum      = 8'd0;
                    n_csum_bad = 1'b0;
                end else begin
                    n_state = S_HUNT;
                end
            end
        endcase
    end

    // State update, one byte per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_HUNT;
            r_sum      <= 8'd0;
            r_hi       <= 8'd0;
            r_lo       <= 8'd0;
            r_csum_bad <= 1'b0;
        end else if (i_step) begin
            r_state    <= n_state;
            r_sum      <= n_sum;
            r_hi       <= n_hi;
            r_lo       <= n_lo;
            r_csum_bad <= n_csum_bad;
        end
    end

endmodule

>>> hdl/dsfd_result_reg.sv
// Result stage: scales the count to a concentration and holds the output word.
// Depends on dsfd_pkg.
module dsfd_result_reg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dsfd_pkg::t_frame_res                 i_res,
    input  logic                                i_take,
    output logic                                o_valid,
    output logic [dsfd_pkg::CONC_W-1:0]         o_concentration,
    output logic [dsfd_pkg::RAW_W-1:0]          o_raw_count,
    output dsfd_pkg::t_status                   o_status
);
    import dsfd_pkg::*;

    localparam int PROD_W = CONC_W + 2;

    logic                r_valid;
    logic [CONC_W-1:0]   r_conc;
    logic [RAW_W-1:0]    r_raw;
    t_status             r_status;
    logic [PROD_W-1:0]   n_prod;
    logic [CONC_W-1:0]   n_conc;

    // raw * 25 / 4, truncated; zero on a bad frame
    always_comb begin
        n_prod = {{(PROD_W-RAW_W){1'b0}}, i_res.raw} * PROD_W'(25);
        n_conc = (i_res.status == ST_OK) ? n_prod[PROD_W-1:2] : '0;
    end

    // Valid flag: set on a finished frame, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res.done) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_res.done) begin
            r_conc   <= n_conc;
            r_raw    <= i_res.raw;
            r_status <= i_res.status;
        end
    end

    assign o_valid         = r_valid;
    assign o_concentration = r_conc;
    assign o_raw_count     = r_raw;
    assign o_status        = r_status;

endmodule

>>> hdl/dust_sensor_frame_decoder.sv
// Top level of the dust sensor frame decoder: input register, frame tracker,
// result register. Depends on dsfd_pkg, dsfd_frame_fsm, dsfd_result_reg.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------------
//  in      | i_in_valid / o_in_stall   | i_rx_byte[7:0]
//  out     | o_out_valid / i_out_stall | o_concentration[18:0] o_raw_count[15:0]
//          |                           | o_status[1:0]
//
// One byte per cycle while the input is not stalled; a tail byte passes the input register,
// then the tracker, and its result is held in the result register.
// Synchronous active-low reset returns the tracker to header hunt, no word held.
// A stall on the output holds the result; the input stalls only while a byte
// waits in the input register and the result register cannot be freed.
module dust_sensor_frame_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [dsfd_pkg::CONC_W-1:0] o_concentration,
    output logic [dsfd_pkg::RAW_W-1:0]  o_raw_count,
    output logic [1:0]                  o_status
);
    import dsfd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       out_free;
    logic       advance;
    logic       step;
    t_frame_res frame_res;
    t_status    status;

    // Pipeline moves when the result register is empty or being taken
    assign out_free   = !o_out_valid || !i_out_stall;
    assign advance    = !r_in_valid || out_free;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = !advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    dsfd_frame_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_res   (frame_res)
    );

    dsfd_result_reg u_res (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_res           (frame_res),
        .i_take          (!i_out_stall),
        .o_valid         (o_out_valid),
        .o_concentration (o_concentration),
        .o_raw_count     (o_raw_count),
        .o_status        (status)
    );

    assign o_status = status;

endmodule
